>>> rtl/cnf_pkg.sv
`timescale 1ns / 1ps
package cnf_pkg;

  localparam int TABLE_SIZE    = 2048;
  localparam int MAX_POINTS    = 6;
  localparam int SEARCH_RADIUS = 3;

  localparam int OCTAVE_LIMIT = 5;
  localparam int AMP_FLOOR    = 66;
  localparam int ONE_Q16      = 65536;
  localparam int SUM_MAX      = 20'hFFFFF;

  // transaction kinds
  localparam logic [1:0] KIND_PERM  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_OCTAVES     = 2'd0;
  localparam logic [1:0] REG_PERSISTENCE = 2'd1;
  localparam logic [1:0] REG_OFFSET_X    = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y    = 2'd3;

  localparam logic [2:0]  RST_OCTAVES     = 3'd5;
  localparam logic [15:0] RST_PERSISTENCE = 16'd19661;
  localparam logic [10:0] RST_OFFSET_X    = 11'd155;
  localparam logic [10:0] RST_OFFSET_Y    = 11'd255;

  // squared distances stay below 2^37; one spare bit
  localparam int DIST_W = 38;
  localparam int ROOT_W = DIST_W / 2;

endpackage

>>> rtl/cellular_noise_f2_minus_f1_unit.sv
`timescale 1ns / 1ps
// Fractal cellular noise (F2 minus F1). Kind 0 and kind 1 transactions load the permutation
// table and the per-cell feature points and leave the block idle; a kind 2 transaction is a
// query that returns one Q4.16 noise_value. A query runs on a single sequencer with one
// shared 20x20 multiplier and a bit-serial square root unit: per octave it visits each cell
// of the 7x7 neighbourhood and each of its points, then takes the two roots and the
// weighting. in_stall stays high while a query runs. All tables must be written before a
// query reads them.
module cellular_noise_f2_minus_f1_unit #(
  parameter int TABLE_SIZE    = cnf_pkg::TABLE_SIZE,
  parameter int MAX_POINTS    = cnf_pkg::MAX_POINTS,
  parameter int SEARCH_RADIUS = cnf_pkg::SEARCH_RADIUS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [10:0] in_table_index,
  input  logic [10:0] in_perm_value,
  input  logic [2:0]  in_point_slot,
  input  logic [2:0]  in_point_total,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [26:0] in_query_x,
  input  logic [26:0] in_query_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_noise_value
);

  localparam int TBITS = $clog2(TABLE_SIZE);
  localparam int PBITS = $clog2(TABLE_SIZE * MAX_POINTS);
  localparam int WB    = (TBITS > 11) ? TBITS : 11;
  localparam int SPAN  = 2 * SEARCH_RADIUS;
  localparam int DW    = cnf_pkg::DIST_W;
  localparam int RW    = cnf_pkg::ROOT_W;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_OCT      = 5'd1;
  localparam logic [4:0] S_PERM     = 5'd2;
  localparam logic [4:0] S_CNT      = 5'd3;
  localparam logic [4:0] S_NUM      = 5'd4;
  localparam logic [4:0] S_PADDR    = 5'd5;
  localparam logic [4:0] S_PDATA    = 5'd6;
  localparam logic [4:0] S_MX       = 5'd7;
  localparam logic [4:0] S_MY       = 5'd8;
  localparam logic [4:0] S_ACC      = 5'd9;
  localparam logic [4:0] S_CELL_END = 5'd10;
  localparam logic [4:0] S_SQ1_GO   = 5'd11;
  localparam logic [4:0] S_SQ1_WAIT = 5'd12;
  localparam logic [4:0] S_SQ2_GO   = 5'd13;
  localparam logic [4:0] S_SQ2_WAIT = 5'd14;
  localparam logic [4:0] S_TERM     = 5'd15;
  localparam logic [4:0] S_TERM_ACC = 5'd16;
  localparam logic [4:0] S_AMP      = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0] state_r;

  logic [2:0]  octaves_r;
  logic [15:0] persistence_r;
  logic [10:0] offset_x_r;
  logic [10:0] offset_y_r;

  logic [27:0] qx_r, qy_r;
  logic [2:0]  oct_r, noct_r;
  logic [16:0] amp_r;
  logic [19:0] sum_r;
  logic [TBITS-1:0] xm_r, ym_r, cell_r;
  logic [15:0] kx_r, ky_r;
  logic [2:0]  ii_r, jj_r;
  logic [3:0]  npts_r, slot_r;
  logic [19:0] adx_r, ady_r;
  logic [39:0] mul_r, sq_r;
  logic [DW-1:0] best_r, min1_r, min2_r;
  logic [RW-1:0] r1_r;
  logic        out_valid_r;
  logic [19:0] out_noise_r;

  logic        in_acc;
  logic [31:0] cx, cy;
  logic [19:0] mul_a, mul_b;
  logic [20:0] dxs, dys;
  logic [DW-1:0] dist_sq;
  logic [WB-1:0] perm_ext;
  logic [24:0] sum_ext;

  // memories
  logic             perm_we, cnt_we, pt_we;
  logic [TBITS-1:0] perm_addr, cnt_addr;
  logic [PBITS-1:0] pt_addr;
  logic [10:0]      perm_q;
  logic [2:0]       cnt_q;
  logic [31:0]      pt_q;

  logic          sq_start, sq_done;
  logic [DW-1:0] sq_din;
  logic [RW-1:0] sq_root;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_noise_value = out_noise_r;

  always_comb begin
    perm_we = in_acc && (in_kind == cnf_pkg::KIND_PERM) && (32'(in_table_index) < TABLE_SIZE);
    pt_we   = in_acc && (in_kind == cnf_pkg::KIND_POINT) && (32'(in_table_index) < TABLE_SIZE)
              && (32'(in_point_slot) < MAX_POINTS);
    cnt_we  = pt_we;
    cx      = 32'(qx_r) << oct_r;
    cy      = 32'(qy_r) << oct_r;
    perm_ext = WB'(perm_q);
    if (state_r == S_IDLE) begin
      perm_addr = TBITS'(in_table_index);
      cnt_addr  = TBITS'(in_table_index);
      pt_addr   = PBITS'(32'(in_table_index) * MAX_POINTS + 32'(in_point_slot));
    end else begin
      perm_addr = xm_r + TBITS'(ii_r) - TBITS'(SEARCH_RADIUS);
      cnt_addr  = ym_r + TBITS'(jj_r) - TBITS'(SEARCH_RADIUS) + perm_ext[TBITS-1:0];
      pt_addr   = PBITS'(32'(cell_r) * MAX_POINTS + 32'(slot_r));
    end
    // offsets relative to the point: fraction - (i*1.0) - point, modulo 2^21
    dxs = 21'(kx_r) + 21'(SEARCH_RADIUS * 65536) - {2'b00, ii_r, 16'h0000} - 21'(pt_q[31:16]);
    dys = 21'(ky_r) + 21'(SEARCH_RADIUS * 65536) - {2'b00, jj_r, 16'h0000} - 21'(pt_q[15:0]);
    dist_sq = DW'(sq_r) + DW'(mul_r);
    sum_ext = 25'(sum_r) + 25'(mul_r[39:16]);
    case (state_r)
      S_MX:     begin mul_a = adx_r;               mul_b = adx_r; end
      S_MY:     begin mul_a = ady_r;               mul_b = ady_r; end
      S_TERM:   begin mul_a = 20'(amp_r);          mul_b = 20'(sq_root - r1_r); end
      default:  begin mul_a = 20'(amp_r);          mul_b = 20'(persistence_r); end
    endcase
    sq_start = (state_r == S_SQ1_GO) || (state_r == S_SQ2_GO);
    sq_din   = (state_r == S_SQ1_GO) ? min1_r : min2_r;
  end

  cnf_ram #(.WIDTH(11), .DEPTH(TABLE_SIZE)) u_perm (
    .clk(clk), .we(perm_we), .addr(perm_addr), .wdata(in_perm_value), .rdata_r(perm_q)
  );

  cnf_ram #(.WIDTH(3), .DEPTH(TABLE_SIZE)) u_count (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(in_point_total), .rdata_r(cnt_q)
  );

  cnf_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE * MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .addr(pt_addr), .wdata({in_point_x, in_point_y}), .rdata_r(pt_q)
  );

  cnf_isqrt #(.DW(DW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .din(sq_din), .done_r(sq_done),
    .root_r(sq_root)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octaves_r     <= cnf_pkg::RST_OCTAVES;
      persistence_r <= cnf_pkg::RST_PERSISTENCE;
      offset_x_r    <= cnf_pkg::RST_OFFSET_X;
      offset_y_r    <= cnf_pkg::RST_OFFSET_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cnf_pkg::REG_OCTAVES:     octaves_r     <= cfg_data[2:0];
        cnf_pkg::REG_PERSISTENCE: persistence_r <= cfg_data;
        cnf_pkg::REG_OFFSET_X:    offset_x_r    <= cfg_data[10:0];
        cnf_pkg::REG_OFFSET_Y:    offset_y_r    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_kind == cnf_pkg::KIND_QUERY) begin
            qx_r   <= 28'(in_query_x) + {1'b0, offset_x_r, 16'h0000};
            qy_r   <= 28'(in_query_y) + {1'b0, offset_y_r, 16'h0000};
            noct_r <= (32'(octaves_r) > cnf_pkg::OCTAVE_LIMIT)
                      ? 3'(cnf_pkg::OCTAVE_LIMIT) : octaves_r;
            oct_r  <= '0;
            amp_r  <= 17'(cnf_pkg::ONE_Q16);
            sum_r  <= '0;
            state_r <= S_OCT;
          end
        end
        S_OCT: begin
          if (oct_r < noct_r && 32'(amp_r) >= cnf_pkg::AMP_FLOOR) begin
            xm_r   <= cx[16 +: TBITS];
            ym_r   <= cy[16 +: TBITS];
            kx_r   <= cx[15:0];
            ky_r   <= cy[15:0];
            ii_r   <= '0;
            jj_r   <= '0;
            min1_r <= '1;
            min2_r <= '1;
            state_r <= S_PERM;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_PERM: state_r <= S_CNT;
        S_CNT: begin
          cell_r  <= cnt_addr;
          state_r <= S_NUM;
        end
        S_NUM: begin
          if (cnt_q == 3'd0) begin
            npts_r <= 4'd1;
          end else if (32'(cnt_q) > MAX_POINTS) begin
            npts_r <= 4'(MAX_POINTS);
          end else begin
            npts_r <= 4'(cnt_q);
          end
          slot_r  <= '0;
          best_r  <= '1;
          state_r <= S_PADDR;
        end
        S_PADDR: state_r <= S_PDATA;
        S_PDATA: begin
          adx_r   <= dxs[20] ? 20'(-dxs) : dxs[19:0];
          ady_r   <= dys[20] ? 20'(-dys) : dys[19:0];
          state_r <= S_MX;
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          sq_r    <= mul_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (dist_sq < best_r) begin
            best_r <= dist_sq;
          end
          slot_r  <= slot_r + 1'b1;
          state_r <= (slot_r + 1'b1 == npts_r) ? S_CELL_END : S_PADDR;
        end
        S_CELL_END: begin
          if (best_r < min1_r) begin
            min2_r <= min1_r;
            min1_r <= best_r;
          end else if (best_r < min2_r) begin
            min2_r <= best_r;
          end
          if (ii_r == 3'(SPAN)) begin
            ii_r <= '0;
            if (jj_r == 3'(SPAN)) begin
              state_r <= S_SQ1_GO;
            end else begin
              jj_r    <= jj_r + 1'b1;
              state_r <= S_PERM;
            end
          end else begin
            ii_r    <= ii_r + 1'b1;
            state_r <= S_PERM;
          end
        end
        S_SQ1_GO: state_r <= S_SQ1_WAIT;
        S_SQ1_WAIT: begin
          if (sq_done) begin
            r1_r    <= sq_root;
            state_r <= S_SQ2_GO;
          end
        end
        S_SQ2_GO: state_r <= S_SQ2_WAIT;
        S_SQ2_WAIT: begin
          if (sq_done) begin
            state_r <= S_TERM;
          end
        end
        S_TERM: state_r <= S_TERM_ACC;
        S_TERM_ACC: begin
          sum_r   <= (sum_ext > 25'(cnf_pkg::SUM_MAX)) ? 20'(cnf_pkg::SUM_MAX) : sum_ext[19:0];
          state_r <= S_AMP;
        end
        S_AMP: begin
          amp_r   <= mul_r[32:16];
          oct_r   <= oct_r + 1'b1;
          state_r <= S_OCT;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_noise_r <= sum_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_sqrt_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |=> !sq_done)
    else $error("square root restarted while finishing");

  a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ1_GO) |-> (min1_r <= min2_r))
    else $error("nearest distances out of order");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == cnf_pkg::KIND_QUERY) |=> (state_r == S_OCT))
    else $error("query did not start");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind != cnf_pkg::KIND_QUERY) |=> !in_stall)
    else $error("load transaction left the block busy");

endmodule

>>> rtl/cnf_ram.sv
`timescale 1ns / 1ps
module cnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

>>> rtl/cnf_isqrt.sv
`timescale 1ns / 1ps
// Floor square root, one result bit per cycle.
module cnf_isqrt #(
  parameter int DW = cnf_pkg::DIST_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DW-1:0]   din,
  output logic            done_r,
  output logic [DW/2-1:0] root_r
);

  localparam int RW = DW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [DW-1:0] val_r;
  logic [RW+1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;

  logic [RW+1:0] rem_s;
  logic [RW+1:0] trial;
  logic          ge;

  always_comb begin
    rem_s = {rem_r[RW-1:0], val_r[DW-1:DW-2]};
    trial = {root_r, 2'b01};
    ge    = rem_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= din;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[DW-3:0], 2'b00};
      rem_r  <= ge ? rem_s - trial : rem_s;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

endmodule

>>> tb/sv/cellular_noise_checker.sv
`timescale 1ns / 1ps
module cellular_noise_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [10:0] in_table_index,
  input  logic [10:0] in_perm_value,
  input  logic [2:0]  in_point_slot,
  input  logic [2:0]  in_point_total,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [26:0] in_query_x,
  input  logic [26:0] in_query_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [19:0] out_noise_value,
  output int          mismatches,
  output int          pending
);

  logic [10:0] perm_mirror [cnf_pkg::TABLE_SIZE];
  logic [2:0]  count_mirror [cnf_pkg::TABLE_SIZE];
  logic [31:0] point_mirror [cnf_pkg::TABLE_SIZE * cnf_pkg::MAX_POINTS];

  logic [2:0]  octaves_q;
  logic [15:0] persist_q;
  logic [10:0] offx_q;
  logic [10:0] offy_q;

  logic [19:0] expected_noise [$];

  assign pending = expected_noise.size();

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned nearest_sq(int cidx, longint fx, longint fy);
    int n;
    longint dx;
    longint dy;
    longint unsigned d;
    longint unsigned best;
    logic [31:0] pt;
    n = int'(count_mirror[cidx]);
    if (n == 0) n = 1;
    if (n > cnf_pkg::MAX_POINTS) n = cnf_pkg::MAX_POINTS;
    best = '1;
    for (int s = 0; s < n; s++) begin
      pt = point_mirror[cidx * cnf_pkg::MAX_POINTS + s];
      dx = fx - longint'(pt[31:16]);
      dy = fy - longint'(pt[15:0]);
      d = unsigned'(dx * dx) + unsigned'(dy * dy);
      if (d < best) best = d;
    end
    return best;
  endfunction

  function automatic longint unsigned f2_minus_f1(longint unsigned cx, longint unsigned cy);
    int xm;
    int ym;
    int col;
    int cidx;
    longint kx;
    longint ky;
    longint unsigned d;
    longint unsigned m1;
    longint unsigned m2;
    xm = int'((cx >> 16) % cnf_pkg::TABLE_SIZE);
    ym = int'((cy >> 16) % cnf_pkg::TABLE_SIZE);
    kx = longint'(cx & 64'hFFFF);
    ky = longint'(cy & 64'hFFFF);
    m1 = '1;
    m2 = '1;
    for (int j = -cnf_pkg::SEARCH_RADIUS; j <= cnf_pkg::SEARCH_RADIUS; j++) begin
      for (int i = -cnf_pkg::SEARCH_RADIUS; i <= cnf_pkg::SEARCH_RADIUS; i++) begin
        col = (xm + cnf_pkg::TABLE_SIZE + i) % cnf_pkg::TABLE_SIZE;
        cidx = (ym + cnf_pkg::TABLE_SIZE + j + int'(perm_mirror[col])) % cnf_pkg::TABLE_SIZE;
        d = nearest_sq(cidx, kx - longint'(i) * 65536, ky - longint'(j) * 65536);
        if (d < m1) begin
          m2 = m1;
          m1 = d;
        end else if (d < m2) begin
          m2 = d;
        end
      end
    end
    return root_floor(m2) - root_floor(m1);
  endfunction

  function automatic logic [19:0] noise_at(logic [26:0] qx, logic [26:0] qy);
    longint unsigned px;
    longint unsigned py;
    longint unsigned amp;
    longint unsigned total;
    int n;
    px = 64'(qx) + (64'(offx_q) << 16);
    py = 64'(qy) + (64'(offy_q) << 16);
    n = (octaves_q > cnf_pkg::OCTAVE_LIMIT) ? cnf_pkg::OCTAVE_LIMIT : int'(octaves_q);
    amp = 64'(cnf_pkg::ONE_Q16);
    total = 0;
    for (int o = 0; o < n && amp >= cnf_pkg::AMP_FLOOR; o++) begin
      total = total + ((amp * f2_minus_f1(px << o, py << o)) >> 16);
      if (total > cnf_pkg::SUM_MAX) total = 64'(cnf_pkg::SUM_MAX);
      amp = (amp * persist_q) >> 16;
    end
    return total[19:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      octaves_q  <= cnf_pkg::RST_OCTAVES;
      persist_q  <= cnf_pkg::RST_PERSISTENCE;
      offx_q     <= cnf_pkg::RST_OFFSET_X;
      offy_q     <= cnf_pkg::RST_OFFSET_Y;
      mismatches <= 0;
      expected_noise.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cnf_pkg::REG_OCTAVES:     octaves_q <= cfg_data[2:0];
          cnf_pkg::REG_PERSISTENCE: persist_q <= cfg_data;
          cnf_pkg::REG_OFFSET_X:    offx_q    <= cfg_data[10:0];
          cnf_pkg::REG_OFFSET_Y:    offy_q    <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_kind)
          cnf_pkg::KIND_PERM: perm_mirror[in_table_index] = in_perm_value;
          cnf_pkg::KIND_POINT: begin
            if (in_point_slot < cnf_pkg::MAX_POINTS) begin
              count_mirror[in_table_index] = in_point_total;
              point_mirror[in_table_index * cnf_pkg::MAX_POINTS + in_point_slot] =
                {in_point_x, in_point_y};
            end
          end
          cnf_pkg::KIND_QUERY:
            expected_noise = {expected_noise, noise_at(in_query_x, in_query_y)};
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_noise.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: noise_value %h", out_noise_value);
          mismatches <= mismatches + 1;
        end else begin
          if (out_noise_value !== expected_noise[0]) begin
            if (mismatches < 10)
              $display("noise_value mismatch: expected %h actual %h",
                       expected_noise[0], out_noise_value);
            mismatches <= mismatches + 1;
          end
          void'(expected_noise.pop_front());
        end
      end
    end
  end

endmodule

>>> tb/sv/cellular_noise_f2_minus_f1_unit_test.sv
`timescale 1ns / 1ps
module cellular_noise_f2_minus_f1_unit_test;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int unsigned Q_MAX = 32'h07FF_FFFF;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [10:0] in_table_index = '0;
  logic [10:0] in_perm_value = '0;
  logic [2:0]  in_point_slot = '0;
  logic [2:0]  in_point_total = '0;
  logic [15:0] in_point_x = '0;
  logic [15:0] in_point_y = '0;
  logic [26:0] in_query_x = '0;
  logic [26:0] in_query_y = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [19:0] out_noise_value;

  int mismatches;
  int pending;
  int cycles = 0;
  bit fast_send = 0;
  bit fast_recv = 0;
  bit hold_req = 0;
  int filled [cnf_pkg::TABLE_SIZE];

  always #4 clk = ~clk;

  cellular_noise_f2_minus_f1_unit dut (.*);

  cellular_noise_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall per transaction, plus one long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        w = fast_recv ? 0 : $urandom_range(0, 18);
        out_stall = (w != 0);
        repeat (w) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic offer(logic [1:0] kind, int unsigned idx, int unsigned pv,
                       int unsigned slot, int unsigned total, int unsigned px,
                       int unsigned py, int unsigned qx, int unsigned qy, bit nogap);
    int w;
    w = (fast_send || nogap) ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (w != 0) begin
      in_valid = 0;
      repeat (w - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid = 1;
    in_kind = kind;
    in_table_index = 11'(idx);
    in_perm_value = 11'(pv);
    in_point_slot = 3'(slot);
    in_point_total = 3'(total);
    in_point_x = 16'(px);
    in_point_y = 16'(py);
    in_query_x = 27'(qx);
    in_query_y = 27'(qy);
    do @(posedge clk); while (in_stall);
    if (kind == cnf_pkg::KIND_POINT && slot < cnf_pkg::MAX_POINTS
        && filled[11'(idx)] < int'(slot) + 1)
      filled[11'(idx)] = int'(slot) + 1;
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    in_valid = 0;
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 16'(value);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  // point write that never makes a query read an unwritten slot
  task automatic random_point();
    int unsigned idx;
    int f;
    int slot;
    int nf;
    int total;
    idx = $urandom_range(0, cnf_pkg::TABLE_SIZE - 1);
    f = filled[idx];
    if ($urandom_range(0, 9) == 0) begin
      slot = $urandom_range(cnf_pkg::MAX_POINTS, 7);
      total = $urandom_range(0, 7);
    end else begin
      slot = $urandom_range(0, (f < cnf_pkg::MAX_POINTS) ? f : cnf_pkg::MAX_POINTS - 1);
      nf = (slot + 1 > f) ? slot + 1 : f;
      if ($urandom_range(0, 9) < 7) total = $urandom_range(0, (nf < 2) ? nf : 2);
      else total = $urandom_range(0, nf);
      if (nf == cnf_pkg::MAX_POINTS && $urandom_range(0, 3) == 0) total = 7;
    end
    offer(cnf_pkg::KIND_POINT, idx, $urandom, slot, total, $urandom, $urandom,
          $urandom, $urandom, 1'b0);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25)
      offer(cnf_pkg::KIND_PERM, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 1'b0);
    else if (r < 60)
      random_point();
    else if (r < 95)
      offer(cnf_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 1'b0);
    else
      offer(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // load every permutation entry and one point per cell before any query
    for (int k = 0; k < cnf_pkg::TABLE_SIZE; k++) begin
      filled[k] = 0;
      offer(cnf_pkg::KIND_PERM, k, $urandom, 0, 0, 0, 0, 0, 0, $urandom_range(0, 15) != 0);
    end
    for (int k = 0; k < cnf_pkg::TABLE_SIZE; k++)
      offer(cnf_pkg::KIND_POINT, k, 0, 0, 1, $urandom, $urandom, 0, 0,
            $urandom_range(0, 15) != 0);

    // directed corners
    offer(cnf_pkg::KIND_PERM, 0, 32'h7FF, 0, 0, 0, 0, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_PERM, 32'h7FF, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    for (int s = 0; s < cnf_pkg::MAX_POINTS; s++)
      offer(cnf_pkg::KIND_POINT, 5, 0, s, cnf_pkg::MAX_POINTS, (s % 2) ? 32'hFFFF : 32'h0,
            (s % 2) ? 32'h0 : 32'hFFFF, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_POINT, 5, 0, 5, 7, 32'hFFFF, 32'hFFFF, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_POINT, 6, 0, 0, 0, 32'h8000, 32'h8000, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_POINT, 7, 0, 6, 3, 32'h1234, 32'h4321, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_POINT, 8, 0, 7, 7, 32'hFFFF, 32'hFFFF, 0, 0, 1'b0);
    offer(KIND_UNUSED, 32'h7FF, 32'h7FF, 7, 7, 32'hFFFF, 32'hFFFF, Q_MAX, Q_MAX, 1'b0);
    offer(cnf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    offer(cnf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, 1'b0);
    offer(cnf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, Q_MAX, 0, 1'b0);
    offer(cnf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, Q_MAX, 1'b0);
    offer(cnf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 32'h5 << 16, 32'h3 << 16, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(cnf_pkg::REG_OCTAVES, 1);
          write_reg(cnf_pkg::REG_PERSISTENCE, 0);
          write_reg(cnf_pkg::REG_OFFSET_X, 0);
          write_reg(cnf_pkg::REG_OFFSET_Y, 0);
        end
        1: begin
          write_reg(cnf_pkg::REG_OCTAVES, 5);
          write_reg(cnf_pkg::REG_PERSISTENCE, 32'hFFFF);
          write_reg(cnf_pkg::REG_OFFSET_X, 32'h7FF);
          write_reg(cnf_pkg::REG_OFFSET_Y, 32'h7FF);
        end
        2: begin
          write_reg(cnf_pkg::REG_OCTAVES, 0);
          hold_req = 1;
        end
        3: write_reg(cnf_pkg::REG_OCTAVES, 7);
        4: begin
          write_reg(cnf_pkg::REG_OCTAVES, 3);
          write_reg(cnf_pkg::REG_PERSISTENCE, 200);
        end
        default: begin
          write_reg(cnf_pkg::REG_OCTAVES, $urandom_range(1, 5));
          write_reg(cnf_pkg::REG_PERSISTENCE, $urandom);
          write_reg(cnf_pkg::REG_OFFSET_X, $urandom);
          write_reg(cnf_pkg::REG_OFFSET_Y, $urandom);
        end
      endcase
      fast_send = (phase % 3 == 1);
      fast_recv = (phase % 4 == 2);
      for (int n = 0; n < 50; n++) random_item();
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cnf_pkg.sv
rtl/cnf_ram.sv
rtl/cnf_isqrt.sv
rtl/cellular_noise_f2_minus_f1_unit.sv
tb/sv/cellular_noise_checker.sv
tb/sv/cellular_noise_f2_minus_f1_unit_test.sv
